// ----- rtl/fwp_pkg.sv -----
package fwp_pkg;

   // wake cause codes
   typedef enum logic [1:0] {
      CAUSE_COLD  = 2'd0,
      CAUSE_TIMER = 2'd1,
      CAUSE_PIN   = 2'd2,
      CAUSE_OTHER = 2'd3
   } wake_cause_type;

   // level machine states
   typedef enum logic [1:0] {
      LVL_NORMAL      = 2'd0,
      LVL_LOW_PENDING = 2'd1,
      LVL_WAIT_HIGH   = 2'd2
   } level_state_type;

   // configuration register indexes
   localparam logic [1:0] CSR_NORMAL_SLEEP = 2'd0;
   localparam logic [1:0] CSR_LOW_CONFIRM  = 2'd1;
   localparam logic [1:0] CSR_WAIT_HIGH    = 2'd2;
   localparam logic [1:0] CSR_FINAL_COPIES = 2'd3;

   localparam logic [15:0] NORMAL_SLEEP_RST = 16'd60;
   localparam logic [15:0] LOW_CONFIRM_RST  = 16'd30;
   localparam logic [15:0] WAIT_HIGH_RST    = 16'd60;
   localparam logic [2:0]  FINAL_COPIES_RST = 3'd3;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   typedef struct packed {
      logic [15:0] normal_sleep_seconds;
      logic [15:0] low_confirm_seconds;
      logic [15:0] wait_high_seconds;
      logic [2:0]  final_report_copies;
   } cfg_type;

   // packed MSB first: first field ends up in the high bits
   typedef struct packed {
      logic           prev_delivery_ok;
      logic           alert_wake;
      logic           high_closed;
      logic           low_closed;
      wake_cause_type wake_cause;
   } req_item_type;

   typedef struct packed {
      logic [2:0]      float_copies;
      logic            reported_high;
      logic            reported_low;
      logic            watch_alert;
      logic            watch_high;
      logic            watch_low;
      logic [15:0]     sleep_seconds;
      logic            report_fault;
      logic            report_floats;
      logic            report_temperature;
      logic            use_radio;
      level_state_type next_level_state;
   } rsp_item_type;

endpackage

// ----- rtl/fwp_csr.sv -----
module fwp_csr
   import fwp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NORMAL_SLEEP: cfg_in.normal_sleep_seconds = csr_data;
            CSR_LOW_CONFIRM:  cfg_in.low_confirm_seconds  = csr_data;
            CSR_WAIT_HIGH:    cfg_in.wait_high_seconds    = csr_data;
            CSR_FINAL_COPIES: cfg_in.final_report_copies  = csr_data[2:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_sleep_seconds <= NORMAL_SLEEP_RST;
         cfg_ff.low_confirm_seconds  <= LOW_CONFIRM_RST;
         cfg_ff.wait_high_seconds    <= WAIT_HIGH_RST;
         cfg_ff.final_report_copies  <= FINAL_COPIES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/fwp_core.sv -----
module fwp_core
   import fwp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  cfg_type      cfg,
   input  req_item_type item,
   output rsp_item_type result
);

   level_state_type level_state_ff, level_state_in;
   logic final_pending_ff, final_pending_in;
   logic latched_low_ff, latched_low_in;
   logic latched_high_ff, latched_high_in;
   logic fault_known_ff, fault_known_in;
   logic fault_last_ff, fault_last_in;
   logic fault_out_ff, fault_out_in;
   logic fault_val_ff, fault_val_in;

   function automatic logic [15:0] min_one16(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   always_comb begin
      logic cold, timer, alert_pin, fault_now, low, high;
      level_state_type cur, next;
      logic radio, rep_t, rep_f, rep_x, w_low, w_high, w_alert, r_low, r_high;
      logic [15:0] sleep;
      logic [2:0] copies;

      low       = item.low_closed;
      high      = item.high_closed;
      cold      = (item.wake_cause == CAUSE_COLD);
      timer     = (item.wake_cause == CAUSE_TIMER);
      alert_pin = item.alert_wake && (item.wake_cause == CAUSE_PIN);
      fault_now = low && !high;

      // book the previous item's delivery
      fault_known_in   = fault_known_ff;
      fault_last_in    = fault_last_ff;
      final_pending_in = final_pending_ff;
      latched_low_in   = latched_low_ff;
      latched_high_in  = latched_high_ff;
      if (item.prev_delivery_ok) begin
         if (fault_out_ff) begin
            fault_known_in = 1'b1;
            fault_last_in  = fault_val_ff;
         end
         final_pending_in = 1'b0;
      end

      cur = cold ? LVL_NORMAL : level_state_ff;

      // high float opened while waiting: take final snapshot
      if (cur == LVL_WAIT_HIGH && !high) begin
         final_pending_in = 1'b1;
         latched_low_in   = low;
         latched_high_in  = high;
      end

      next    = LVL_NORMAL;
      radio   = 1'b0;
      rep_t   = 1'b0;
      rep_f   = 1'b0;
      rep_x   = 1'b0;
      w_low   = 1'b0;
      w_high  = 1'b0;
      w_alert = 1'b0;
      sleep   = cfg.normal_sleep_seconds;

      if (cur == LVL_LOW_PENDING) begin
         if (!low) begin
            w_low   = 1'b1;
            w_alert = 1'b1;
         end else if (!timer) begin
            next  = LVL_LOW_PENDING;
            sleep = cfg.low_confirm_seconds;
            w_low = 1'b1;
         end else if (!high) begin
            radio   = 1'b1;
            rep_t   = 1'b1;
            rep_x   = 1'b1;
            w_low   = 1'b1;
            w_high  = 1'b1;
            w_alert = 1'b1;
         end else begin
            next    = LVL_WAIT_HIGH;
            radio   = 1'b1;
            rep_t   = 1'b1;
            rep_f   = 1'b1;
            w_high  = 1'b1;
            w_alert = 1'b1;
            sleep   = cfg.wait_high_seconds;
         end
      end else if (cur == LVL_WAIT_HIGH) begin
         if (!high) begin
            radio   = 1'b1;
            rep_t   = 1'b1;
            rep_f   = 1'b1;
            w_low   = 1'b1;
            w_alert = 1'b1;
         end else begin
            next    = LVL_WAIT_HIGH;
            w_high  = 1'b1;
            w_alert = 1'b1;
            sleep   = cfg.wait_high_seconds;
            if (timer) begin
               radio = 1'b1;
               rep_t = 1'b1;
            end
            if (alert_pin) begin
               radio = 1'b1;
               rep_t = 1'b0;
            end
         end
      end else begin
         if (fault_now) begin
            radio   = 1'b1;
            rep_t   = 1'b1;
            rep_x   = 1'b1;
            w_low   = 1'b1;
            w_high  = 1'b1;
            w_alert = 1'b1;
         end else if (low) begin
            next  = LVL_LOW_PENDING;
            sleep = cfg.low_confirm_seconds;
            w_low = 1'b1;
         end else begin
            w_low   = 1'b1;
            w_alert = 1'b1;
            radio   = cold || timer;
            rep_t   = radio;
            rep_f   = radio;
            if (alert_pin) begin
               radio = 1'b1;
               rep_t = 1'b0;
               rep_f = 1'b0;
            end
         end
      end

      if (cold && !radio) begin
         radio = 1'b1;
         rep_t = 1'b1;
      end
      if (radio) begin
         rep_x = 1'b1;
      end
      // clear a delivered fault once the floats agree again
      if (fault_known_in && fault_last_in && !fault_now && !radio) begin
         radio = 1'b1;
         rep_x = 1'b1;
         rep_t = 1'b0;
         rep_f = 1'b0;
      end

      if (final_pending_in) begin
         next    = LVL_NORMAL;
         radio   = 1'b1;
         rep_f   = 1'b1;
         rep_x   = 1'b1;
         w_low   = 1'b1;
         w_alert = 1'b1;
         r_low   = latched_low_in;
         r_high  = latched_high_in;
         copies  = (cfg.final_report_copies == 3'd0) ? 3'd1 : cfg.final_report_copies;
      end else begin
         r_low  = low;
         r_high = high;
         copies = 3'd1;
      end

      fault_out_in   = radio && rep_x;
      fault_val_in   = radio && rep_x && r_low && !r_high;
      level_state_in = next;

      result.next_level_state   = next;
      result.use_radio          = radio;
      result.report_temperature = rep_t;
      result.report_floats      = rep_f;
      result.report_fault       = rep_x;
      result.sleep_seconds      = min_one16(sleep);
      result.watch_low          = w_low;
      result.watch_high         = w_high;
      result.watch_alert        = w_alert;
      result.reported_low       = r_low;
      result.reported_high      = r_high;
      result.float_copies       = copies;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_state_ff   <= LVL_NORMAL;
         final_pending_ff <= 1'b0;
         latched_low_ff   <= 1'b0;
         latched_high_ff  <= 1'b0;
         fault_known_ff   <= 1'b0;
         fault_last_ff    <= 1'b0;
         fault_out_ff     <= 1'b0;
         fault_val_ff     <= 1'b0;
      end else if (step) begin
         level_state_ff   <= level_state_in;
         final_pending_ff <= final_pending_in;
         latched_low_ff   <= latched_low_in;
         latched_high_ff  <= latched_high_in;
         fault_known_ff   <= fault_known_in;
         fault_last_ff    <= fault_last_in;
         fault_out_ff     <= fault_out_in;
         fault_val_ff     <= fault_val_in;
      end
   end

endmodule

// ----- rtl/float_level_wake_planner_top.sv -----
// Float level wake planner, one result transfer per request transfer.
// Two registers: the input register, then the result register, which drives rsp_tvalid.
// One request per cycle while rsp_tready keeps up; the single-pass plan logic between the
// two registers sets this, and the level state updates as each item enters the result register.
// Reset (synchronous, active high): pipeline empty, level machine normal, all flags clear,
// config registers at 60 / 30 / 60 seconds and 3 copies.
module float_level_wake_planner_top
   import fwp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] wake_cause, [2] low_closed, [3] high_closed, [4] alert_wake,
   // [5] prev_delivery_ok, [7:6] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,

   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] next_level_state, [2] use_radio, [3] report_temperature, [4] report_floats,
   // [5] report_fault, [21:6] sleep_seconds, [22] watch_low, [23] watch_high,
   // [24] watch_alert, [25] reported_low, [26] reported_high, [29:27] float_copies,
   // [31:30] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   // config write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data
);

   cfg_type cfg;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type plan;

   logic req_xfer;
   logic advance;

   // an item moves forward whenever the result slot is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(rsp_item_type)){1'b0}}, out_item_ff};

   fwp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // plan logic plus the persistent level/fault state; state commits on advance
   fwp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (plan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_tdata[$bits(req_item_type)-1:0];
      end
      if (advance) begin
         out_item_ff <= plan;
      end
   end

endmodule
